@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the join-condition memo table.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/jcmt_pkg.sv @@
// Types and codes of the join-condition memo table.
// No dependencies; imported by join_condition_memo_table.
package jcmt_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [3:0] first;
		logic [3:0] count;
		logic       match;
	} meta_t;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic       matched;
	} result_t;

endpackage

@@ hdl/join_condition_memo_table.sv @@
// Join-condition memo table: key assembly, entry/row memories and the lookup sequencer.
// Depends on jcmt_pkg and assert_macros.svh.
//
// Usage:
// The slave stream carries one key row index per beat; tlast closes the key and
// triggers the command in tuser (lookup, store, clear). Every tlast beat gives
// exactly one result beat on the master stream; other beats give none.
// Beats without tlast do not stall the input. After a tlast beat the input stalls
// until the command finishes: clear and rejected commands finish right after the
// decode state, a store writes one key row per cycle into the row memory, and a
// lookup walks the entries in insertion order, reading each entry's metadata word
// and then comparing its rows with the key one row memory word per cycle.
// The result sits in an output register; a stalled receiver holds it there while
// key beats of the next command are still taken, and a finished command waits for
// the register to drain. Reset empties the table and the key; memory contents are
// not cleared, as only entries below the entry count are ever read.
`include "assert_macros.svh"

module join_condition_memo_table #(
	parameter int MAX_ENTRIES    = 64,
	parameter int MAX_TABLES     = 8,
	parameter int ROW_INDEX_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// range_first[3:0], range_count[7:4], source_count[11:8], row_value[43:12],
	// match_value[44], zero fill [47:45]
	input  logic [jcmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd[1:0]
	input  logic [jcmt_pkg::IN_USER_W-1:0]    s_axis_tuser,
	// key_last
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[1:0], found[2], matched[3], zero fill [7:4]
	output logic [jcmt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import jcmt_pkg::*;

	localparam int EI_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int USED_W = $clog2(MAX_ENTRIES + 1);
	localparam int KI_W   = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int FILL_W = $clog2(MAX_TABLES + 1);
	localparam int ROWS_D = MAX_ENTRIES * MAX_TABLES;
	localparam int RA_W   = (ROWS_D > 1) ? $clog2(ROWS_D) : 1;
	localparam int RW     = ROW_INDEX_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_LK_META,
		S_LK_CHK,
		S_LK_ROW,
		S_ST_ROW,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [1:0]         cmd_q;
	logic [3:0]         first_q;
	logic [3:0]         count_q;
	logic [3:0]         src_q;
	logic               mv_q;
	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  ent_q;
	logic [RA_W-1:0]    base_q;
	logic [RA_W-1:0]    tail_q;
	logic [KI_W-1:0]    idx_q;
	logic [FILL_W-1:0]  fill_q;
	logic               hit_match_q;
	result_t            res_q;
	logic               m_valid_q;
	result_t            m_res_q;

	logic [RW-1:0]      kb_q [MAX_TABLES];
	meta_t              meta_mem [MAX_ENTRIES];
	logic [RW-1:0]      row_mem [ROWS_D];
	meta_t              meta_rd_s1;
	logic [RW-1:0]      row_rd_s1;

	logic               in_beat;
	logic               bad;
	logic               last_idx;
	logic [RW-1:0]      key_row;
	logic               meta_we;
	meta_t              meta_wdata;
	logic               row_we;
	logic [RA_W-1:0]    row_waddr;
	logic [RA_W-1:0]    row_raddr;
	logic               out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 4){1'b0}}, m_res_q.matched, m_res_q.found,
		m_res_q.status};
	assign out_free      = !m_valid_q || m_axis_tready;

	assign bad = (first_q > src_q) || (count_q > (src_q - first_q))
		|| ((32'(first_q) + 32'(count_q)) > MAX_TABLES);
	assign last_idx = ((8'(idx_q) + 8'd1) == 8'(count_q));
	assign key_row  = (FILL_W'(idx_q) < fill_q) ? kb_q[idx_q] : '0;

	always_comb begin
		meta_we          = (state_q == S_OP) && (cmd_q == CMD_STORE) && !bad
			&& (32'(used_q) < MAX_ENTRIES);
		meta_wdata.first = first_q;
		meta_wdata.count = count_q;
		meta_wdata.match = mv_q;
		row_we           = (state_q == S_ST_ROW);
		row_waddr        = RA_W'(tail_q + RA_W'(idx_q));
		if (state_q == S_LK_ROW) begin
			row_raddr = RA_W'(base_q + RA_W'(idx_q) + RA_W'(1));
		end else begin
			row_raddr = base_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && (32'(fill_q) < MAX_TABLES)) begin
			kb_q[fill_q[KI_W-1:0]] <= RW'(s_axis_tdata[43:12]);
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[used_q[EI_W-1:0]] <= meta_wdata;
		end
		meta_rd_s1 <= meta_mem[ent_q[EI_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= key_row;
		end
		row_rd_s1 <= row_mem[row_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_LOOKUP;
			first_q     <= '0;
			count_q     <= '0;
			src_q       <= '0;
			mv_q        <= 1'b0;
			used_q      <= '0;
			ent_q       <= '0;
			base_q      <= '0;
			tail_q      <= '0;
			idx_q       <= '0;
			fill_q      <= '0;
			hit_match_q <= 1'b0;
			res_q       <= '0;
			m_valid_q   <= 1'b0;
			m_res_q     <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (32'(fill_q) < MAX_TABLES) begin
							fill_q <= FILL_W'(fill_q + 1'b1);
						end
						if (s_axis_tlast) begin
							cmd_q   <= s_axis_tuser[1:0];
							first_q <= s_axis_tdata[3:0];
							count_q <= s_axis_tdata[7:4];
							src_q   <= s_axis_tdata[11:8];
							mv_q    <= s_axis_tdata[44];
							state_q <= S_OP;
						end
					end
				end
				S_OP: begin
					idx_q <= '0;
					case (cmd_q)
						CMD_LOOKUP: begin
							if (bad) begin
								res_q   <= '{status: STAT_RANGE, found: 1'b0, matched: 1'b0};
								state_q <= S_FIN;
							end else if (used_q == '0) begin
								res_q   <= '0;
								state_q <= S_FIN;
							end else begin
								res_q   <= '0;
								ent_q   <= '0;
								base_q  <= '0;
								state_q <= S_LK_META;
							end
						end
						CMD_STORE: begin
							if (bad) begin
								res_q   <= '{status: STAT_RANGE, found: 1'b0, matched: 1'b0};
								state_q <= S_FIN;
							end else if (32'(used_q) >= MAX_ENTRIES) begin
								res_q   <= '{status: STAT_FULL, found: 1'b0, matched: 1'b0};
								state_q <= S_FIN;
							end else if (count_q == '0) begin
								res_q   <= '0;
								used_q  <= USED_W'(used_q + 1'b1);
								tail_q  <= RA_W'(tail_q + RA_W'(MAX_TABLES));
								state_q <= S_FIN;
							end else begin
								res_q   <= '0;
								state_q <= S_ST_ROW;
							end
						end
						CMD_CLEAR: begin
							res_q   <= '0;
							used_q  <= '0;
							tail_q  <= '0;
							state_q <= S_FIN;
						end
						default: begin
							res_q   <= '0;
							state_q <= S_FIN;
						end
					endcase
				end
				S_ST_ROW: begin
					if (last_idx) begin
						used_q  <= USED_W'(used_q + 1'b1);
						tail_q  <= RA_W'(tail_q + RA_W'(MAX_TABLES));
						state_q <= S_FIN;
					end else begin
						idx_q <= KI_W'(idx_q + 1'b1);
					end
				end
				S_LK_META: begin
					idx_q   <= '0;
					state_q <= S_LK_CHK;
				end
				S_LK_CHK: begin
					hit_match_q <= meta_rd_s1.match;
					if ((meta_rd_s1.first == first_q) && (meta_rd_s1.count == count_q)) begin
						if (count_q == '0) begin
							res_q   <= '{status: STAT_OK, found: 1'b1,
								matched: meta_rd_s1.match};
							state_q <= S_FIN;
						end else begin
							state_q <= S_LK_ROW;
						end
					end else if ((ent_q + 1'b1) >= used_q) begin
						state_q <= S_FIN;
					end else begin
						ent_q   <= USED_W'(ent_q + 1'b1);
						base_q  <= RA_W'(base_q + RA_W'(MAX_TABLES));
						state_q <= S_LK_META;
					end
				end
				S_LK_ROW: begin
					if (row_rd_s1 != key_row) begin
						if ((ent_q + 1'b1) >= used_q) begin
							state_q <= S_FIN;
						end else begin
							ent_q   <= USED_W'(ent_q + 1'b1);
							base_q  <= RA_W'(base_q + RA_W'(MAX_TABLES));
							state_q <= S_LK_META;
						end
					end else if (last_idx) begin
						res_q   <= '{status: STAT_OK, found: 1'b1, matched: hit_match_q};
						state_q <= S_FIN;
					end else begin
						idx_q <= KI_W'(idx_q + 1'b1);
					end
				end
				S_FIN: begin
					fill_q <= '0;
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_res_q   <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_SAME(a_used_bound, 1'b1, 32'(used_q) <= MAX_ENTRIES, "entry count past capacity")
	`ASSERT_SAME(a_fill_bound, 1'b1, 32'(fill_q) <= MAX_TABLES, "key fill past table count")
	`ASSERT_SAME(a_row_idx, (state_q == S_LK_ROW) || (state_q == S_ST_ROW),
		8'(idx_q) < 8'(count_q), "row index outside key range")
	`ASSERT_NEXT(a_store_adv, (state_q == S_ST_ROW) && last_idx,
		used_q == USED_W'($past(used_q) + 1'b1), "store did not append entry")

endmodule

@@ bench/tb_join_condition_memo_table.sv @@
// Self-checking bench for join_condition_memo_table: key beats in, one result beat per tlast.
// Depends on jcmt_pkg; a shadow of the memo table predicts every result beat.
// Directed keys first, then random keys under changing sender and receiver idling.
module tb_join_condition_memo_table;
	import jcmt_pkg::*;

	class memo_table_shadow;
		localparam int ENTRIES = 64;
		localparam int TABLES  = 8;

		bit [3:0]  ent_first [ENTRIES];
		bit [3:0]  ent_count [ENTRIES];
		bit        ent_match [ENTRIES];
		bit [31:0] ent_rows  [ENTRIES][TABLES];
		int        used = 0;
		bit [31:0] held_key [TABLES];
		int        fill = 0;
		result_t   replies_due[$];
		int        mismatches = 0;

		function bit [31:0] key_at(int pos);
			return (pos < fill && pos < TABLES) ? held_key[pos] : 32'd0;
		endfunction

		function void take_beat(logic [1:0] cmd, bit [3:0] first, bit [3:0] count,
				bit [3:0] src, bit [31:0] row, bit last, bit mv);
			result_t r;
			bit      bad;
			bit      hit;
			bit      same;
			int      f, c, s, e, i;
			if (fill < TABLES) begin
				held_key[fill] = row;
				fill++;
			end
			if (!last)
				return;
			f = int'(first);
			c = int'(count);
			s = int'(src);
			bad = (f > s) || (c > s - f) || (f + c > TABLES);
			r = '0;
			r.status = STAT_OK;
			case (cmd)
				CMD_LOOKUP: begin
					if (bad) begin
						r.status = STAT_RANGE;
					end else begin
						hit = 0;
						for (e = 0; e < used && !hit; e++) begin
							same = (ent_first[e] == first) && (ent_count[e] == count);
							for (i = 0; i < c && same; i++)
								if (ent_rows[e][i] != key_at(i))
									same = 0;
							if (same) begin
								hit = 1;
								r.found = 1'b1;
								r.matched = ent_match[e];
							end
						end
					end
				end
				CMD_STORE: begin
					if (bad) begin
						r.status = STAT_RANGE;
					end else if (used >= ENTRIES) begin
						r.status = STAT_FULL;
					end else begin
						ent_first[used] = first;
						ent_count[used] = count;
						ent_match[used] = mv;
						for (i = 0; i < c; i++)
							ent_rows[used][i] = key_at(i);
						used++;
					end
				end
				CMD_CLEAR: used = 0;
				default: ;
			endcase
			fill = 0;
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [7:0] data);
			result_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: result beat with none expected, actual %h", $time, data);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (data[1:0] !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, data[1:0]);
				mismatches++;
			end
			if (data[2] !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, data[2]);
				mismatches++;
			end
			if (data[3] !== want.matched) begin
				$display("%0t: matched expected %0d actual %0d", $time, want.matched, data[3]);
				mismatches++;
			end
		endfunction
	endclass

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int ITEMS       = 1550;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 50;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	memo_table_shadow shadow = new();
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;
	int        beats_sent = 0;
	int        idle_cycles = 0;
	bit [31:0] key_rows [11];
	bit [3:0]  pool_first[$];
	bit [3:0]  pool_count[$];
	bit [255:0] pool_rows[$];

	join_condition_memo_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_reply(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_join_condition_memo_table NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_beat(input logic [1:0] cmd, input bit [3:0] first, input bit [3:0] count,
			input bit [3:0] src, input bit [31:0] row, input bit last, input bit mv);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		s_axis_tdata  <= {3'b000, mv, row, src, count, first};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		shadow.take_beat(cmd, first, count, src, row, last, mv);
		beats_sent++;
	endtask

	// non-final beats carry random command and range fields
	task automatic send_key(input logic [1:0] cmd, input int first, input int count,
			input int src, input int n, input bit mv);
		int i;
		for (i = 0; i < n - 1; i++)
			push_beat(2'($urandom_range(0, 3)), 4'($urandom_range(0, 8)),
				4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)), key_rows[i], 1'b0,
				1'($urandom_range(0, 1)));
		push_beat(cmd, 4'(first), 4'(count), 4'(src), key_rows[n - 1], 1'b1, mv);
	endtask

	function automatic bit [31:0] pick_row();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 3);
			4:          return 32'hFFFF_FFFF;
			default:    return $urandom;
		endcase
	endfunction

	initial begin
		int         i, k, n, roll, first, count, src, since_clear;
		logic [1:0] cmd;
		bit [255:0] packed_rows;

		since_clear = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		key_rows[0] = 32'd0;
		key_rows[1] = 32'hFFFF_FFFF;
		send_key(CMD_LOOKUP, 0, 0, 0, 1, 1'b0);
		send_key(CMD_STORE, 0, 2, 2, 2, 1'b1);
		send_key(CMD_LOOKUP, 0, 2, 2, 2, 1'b0);
		send_key(CMD_STORE, 0, 2, 5, 2, 1'b0);
		send_key(CMD_LOOKUP, 0, 2, 3, 2, 1'b0);
		send_key(CMD_STORE, 6, 2, 8, 1, 1'b1);
		key_rows[1] = 32'd0;
		send_key(CMD_LOOKUP, 6, 2, 8, 2, 1'b0);
		for (i = 0; i < 11; i++)
			key_rows[i] = i * 32'h1111_1111;
		send_key(CMD_STORE, 0, 8, 8, 9, 1'b1);
		send_key(CMD_LOOKUP, 8, 1, 8, 1, 1'b0);
		send_key(CMD_STORE, 3, 0, 2, 1, 1'b1);
		send_key(CMD_UNUSED, 0, 0, 0, 1, 1'b1);
		send_key(CMD_CLEAR, 5, 7, 1, 1, 1'b1);
		key_rows[0] = 32'd0;
		key_rows[1] = 32'd0;
		send_key(CMD_LOOKUP, 6, 2, 8, 2, 1'b0);

		while (beats_sent < ITEMS) begin
			case ((beats_sent / 200) % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
				default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll == 0 || (since_clear >= 70 && roll < 20))
				cmd = CMD_CLEAR;
			else if (roll == 1)
				cmd = CMD_UNUSED;
			else if (roll < 50)
				cmd = CMD_STORE;
			else
				cmd = CMD_LOOKUP;
			src = $urandom_range(0, 8);
			first = $urandom_range(0, src);
			count = $urandom_range(0, src - first);
			if ($urandom_range(0, 99) < 8) begin
				first = $urandom_range(0, 8);
				count = $urandom_range(0, 8);
			end
			for (i = 0; i < 11; i++)
				key_rows[i] = pick_row();
			if (cmd == CMD_LOOKUP && pool_first.size() > 0 && $urandom_range(0, 99) < 65) begin
				k = $urandom_range(0, pool_first.size() - 1);
				first = int'(pool_first[k]);
				count = int'(pool_count[k]);
				for (i = 0; i < 8; i++)
					key_rows[i] = pool_rows[k][i * 32 +: 32];
				src = $urandom_range(8, first + count);
				if ($urandom_range(0, 4) == 0)
					key_rows[$urandom_range(0, 7)] = pick_row();
			end
			n = (count == 0) ? 1 : count;
			roll = $urandom_range(0, 9);
			if (roll == 0 && n > 1)
				n = n - 1;
			else if (roll == 1)
				n = $urandom_range(1, 11);
			send_key(cmd, first, count, src, n, 1'($urandom_range(0, 1)));
			if (cmd == CMD_CLEAR)
				since_clear = 0;
			if (cmd == CMD_STORE) begin
				since_clear++;
				if (first + count <= src) begin
					packed_rows = '0;
					for (i = 0; i < count && i < n; i++)
						packed_rows[i * 32 +: 32] = key_rows[i];
					pool_first.push_back(4'(first));
					pool_count.push_back(4'(count));
					pool_rows.push_back(packed_rows);
					if (pool_first.size() > 40) begin
						void'(pool_first.pop_front());
						void'(pool_count.pop_front());
						void'(pool_rows.pop_front());
					end
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (shadow.replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
			$display("tb_join_condition_memo_table OK");
		else
			$display("tb_join_condition_memo_table NOT OK");
		$finish;
	end
endmodule
